@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the chunked body decoder modules.
// No dependencies; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset
`define HCBD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");
// Expression must never be true outside reset
`define HCBD_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define HCBD_ASSERT(lbl, clk, rstn, prop)
`define HCBD_NEVER(lbl, clk, rstn, expr)
`endif

`endif

@@ hw/rtl/hcbd_pkg.sv @@
// Types and constants for the chunked body decoder.
// No dependencies; imported by every module of the block.
package hcbd_pkg;

    localparam int unsigned SizeW   = 32;
    localparam int unsigned StatusW = 2;

    // Result status codes
    localparam logic [StatusW-1:0] ST_RUN  = 2'd0;
    localparam logic [StatusW-1:0] ST_DONE = 2'd1;
    localparam logic [StatusW-1:0] ST_ERR  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd0;
    localparam logic [1:0] REG_COLLECT     = 2'd1;

    // Framing characters
    localparam logic [7:0] CHR_CR   = 8'h0d;
    localparam logic [7:0] CHR_LF   = 8'h0a;
    localparam logic [7:0] CHR_SEMI = 8'h3b;

    // Decoded properties of one body byte
    typedef struct packed {
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
        logic       is_semi;
        logic       bad_ext;
    } byte_class_t;

    // One result beat
    typedef struct packed {
        logic [StatusW-1:0] status;
        logic               data_valid;
        logic [7:0]         data_byte;
    } result_t;

endpackage

@@ hw/rtl/hcbd_classify.sv @@
// Byte classifier: hex digit value, framing characters, illegal extension bytes.
// Depends on hcbd_pkg.
module hcbd_classify
    import hcbd_pkg::*;
(
    input  logic [7:0]  byte_in,
    output byte_class_t cls
);

    always_comb
    begin
        // Decode hex digits
        cls.is_hex  = 1'b1;
        cls.hex_val = 4'd0;
        case (byte_in) inside
            [8'h30:8'h39]: cls.hex_val = byte_in[3:0];
            [8'h61:8'h66],
            [8'h41:8'h46]: cls.hex_val = 4'(byte_in[3:0] + 4'd9);
            default:       cls.is_hex = 1'b0;
        endcase

        // Flag control, high, space and separator bytes in an extension
        case (byte_in) inside
            8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a,
            8'h5c, 8'h22, 8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b,
            8'h7d, 8'h20, 8'h7f,
            [8'h00:8'h1f],
            [8'h80:8'hff]: cls.bad_ext = 1'b1;
            default:       cls.bad_ext = 1'b0;
        endcase

        cls.is_cr   = (byte_in == CHR_CR);
        cls.is_lf   = (byte_in == CHR_LF);
        cls.is_semi = (byte_in == CHR_SEMI);
    end

endmodule

@@ hw/rtl/hcbd_step.sv @@
// Chunk framing state machine: size parse, extension, data count, budget check.
// Depends on hcbd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hcbd_step
    import hcbd_pkg::*;
#(
    parameter int unsigned MAX_SIZE_DIGITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [7:0]        byte_in,
    input  byte_class_t       cls,
    input  logic [SizeW-1:0]  max_payload,
    input  logic              collect_payload,
    output result_t           res
);

    localparam int unsigned CntW = $clog2(MAX_SIZE_DIGITS + 1);
    localparam logic [CntW-1:0] CntMax = CntW'(MAX_SIZE_DIGITS);

    typedef enum logic [3:0] {
        PH_FIRST   = 4'd0,
        PH_DIGITS  = 4'd1,
        PH_EXT     = 4'd2,
        PH_SIZE_LF = 4'd3,
        PH_DATA    = 4'd4,
        PH_DATA_CR = 4'd5,
        PH_DATA_LF = 4'd6,
        PH_LAST_CR = 4'd10,
        PH_LAST_LF = 4'd11
    } phase_t;

    phase_t             phase_reg,         phase_next;
    logic [CntW-1:0]    digit_count_reg,   digit_count_next;
    logic [SizeW-1:0]   size_accum_reg,    size_accum_next;
    logic               size_ovf_reg,      size_ovf_next;
    logic [SizeW-1:0]   bytes_left_reg,    bytes_left_next;
    logic [SizeW-1:0]   payload_total_reg, payload_total_next;
    logic [StatusW-1:0] final_status_reg,  final_status_next;

    logic [SizeW-1:0]   room;
    logic               err;
    logic               dvalid;

    // Remaining budget, clamped at zero
    assign room = (max_payload > payload_total_reg) ? (max_payload - payload_total_reg)
                                                    : '0;

    // Next state for one byte
    always_comb
    begin
        phase_next         = phase_reg;
        digit_count_next   = digit_count_reg;
        size_accum_next    = size_accum_reg;
        size_ovf_next      = size_ovf_reg;
        bytes_left_next    = bytes_left_reg;
        payload_total_next = payload_total_reg;
        final_status_next  = final_status_reg;
        err                = 1'b0;
        dvalid             = 1'b0;
        if (final_status_reg == ST_RUN)
        begin
            case (phase_reg)
                PH_FIRST:
                begin
                    if (cls.is_hex)
                    begin
                        size_accum_next  = SizeW'(cls.hex_val);
                        size_ovf_next    = 1'b0;
                        digit_count_next = CntW'(1);
                        phase_next       = PH_DIGITS;
                    end
                    else
                        err = 1'b1;
                end
                PH_DIGITS:
                begin
                    if (cls.is_hex)
                    begin
                        if (digit_count_reg < CntMax)
                        begin
                            if (size_accum_reg[SizeW-1 -: 4] != 4'd0)
                                size_ovf_next = 1'b1;
                            size_accum_next  = {size_accum_reg[SizeW-5:0], cls.hex_val};
                            digit_count_next = digit_count_reg + CntW'(1);
                        end
                        else
                            err = 1'b1;
                    end
                    else if (cls.is_semi)
                        phase_next = PH_EXT;
                    else if (cls.is_cr)
                        phase_next = PH_SIZE_LF;
                    else
                        err = 1'b1;
                end
                PH_EXT:
                begin
                    if (cls.is_cr)
                        phase_next = PH_SIZE_LF;
                    else if (cls.bad_ext)
                        err = 1'b1;
                end
                PH_SIZE_LF:
                begin
                    if (cls.is_lf && !size_ovf_reg)
                    begin
                        if (size_accum_reg > room)
                            err = 1'b1;
                        else if (size_accum_reg != '0)
                        begin
                            bytes_left_next = size_accum_reg;
                            phase_next      = PH_DATA;
                        end
                        else
                            phase_next = PH_LAST_CR;
                    end
                    else
                        err = 1'b1;
                end
                PH_DATA:
                begin
                    if (collect_payload)
                    begin
                        dvalid             = 1'b1;
                        payload_total_next = payload_total_reg + SizeW'(1);
                    end
                    bytes_left_next = bytes_left_reg - SizeW'(1);
                    if (bytes_left_reg == SizeW'(1))
                        phase_next = PH_DATA_CR;
                end
                PH_DATA_CR:
                begin
                    if (cls.is_cr)
                        phase_next = PH_DATA_LF;
                    else
                        err = 1'b1;
                end
                PH_DATA_LF:
                begin
                    if (cls.is_lf)
                        phase_next = PH_FIRST;
                    else
                        err = 1'b1;
                end
                PH_LAST_CR:
                begin
                    if (cls.is_cr)
                        phase_next = PH_LAST_LF;
                    else
                        err = 1'b1;
                end
                PH_LAST_LF:
                begin
                    if (cls.is_lf)
                        final_status_next = ST_DONE;
                    else
                        err = 1'b1;
                end
                default:
                    err = 1'b1;
            endcase
            if (err)
            begin
                final_status_next = ST_ERR;
                dvalid            = 1'b0;
            end
        end
    end

    // Result of the current byte
    assign res.status     = final_status_next;
    assign res.data_valid = dvalid;
    assign res.data_byte  = dvalid ? byte_in : 8'd0;

    // Hold parse state, advance once per processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_FIRST;
            digit_count_reg   <= '0;
            size_accum_reg    <= '0;
            size_ovf_reg      <= 1'b0;
            bytes_left_reg    <= '0;
            payload_total_reg <= '0;
            final_status_reg  <= ST_RUN;
        end
        else if (step_en)
        begin
            phase_reg         <= phase_next;
            digit_count_reg   <= digit_count_next;
            size_accum_reg    <= size_accum_next;
            size_ovf_reg      <= size_ovf_next;
            bytes_left_reg    <= bytes_left_next;
            payload_total_reg <= payload_total_next;
            final_status_reg  <= final_status_next;
        end
    end

    // Completion and error never revert
    `HCBD_ASSERT(a_status_sticky, clk, rst_n,
                 final_status_reg != ST_RUN |=> $stable(final_status_reg))
    // Data phase always has bytes still owed
    `HCBD_NEVER(a_data_nonzero, clk, rst_n,
                phase_reg == PH_DATA && final_status_reg == ST_RUN && bytes_left_reg == '0)
    // Digit counter stays within the size limit
    `HCBD_NEVER(a_digit_limit, clk, rst_n, digit_count_reg > CntMax)

endmodule

@@ hw/rtl/http_chunked_body_decoder.sv @@
// HTTP/1.1 chunked body decoder: one body byte in, one status beat out.
// Input channel: in_valid / in_stall with in_byte. Output channel: out_valid /
// out_stall with status, data_valid and data_byte. Every accepted byte gives
// exactly one output beat, in order.
// A byte passes through the input register, then the framing logic into the
// result register, before it is offered on the output.
// Throughput: one byte per cycle while out_stall is low; the framing state machine
// updates the parse state for each byte, so back-to-back bytes wait only on out_stall.
// When out_stall is held, the result register holds its beat, the input
// register fills and then in_stall rises until the output drains.
// status is 0 while more bytes are needed, 1 once the terminating chunk and
// its CRLF are seen, 2 on a framing, size or budget error; 1 and 2 stay until
// reset. data_valid marks payload bytes when collection is enabled.
// Configuration: cfg_we with cfg_index 0 writes max_payload, index 1 writes
// collect_payload (bit 0); write only while no byte is in flight.
// Reset (rst_n low, asynchronous) empties both registers, restarts parsing at
// the first size digit, and sets max_payload to all ones and collection on.
// Depends on hcbd_pkg, hcbd_classify, hcbd_step and assert_macros.svh.
`include "assert_macros.svh"
module http_chunked_body_decoder
    import hcbd_pkg::*;
#(
    parameter int unsigned MAX_SIZE_DIGITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         in_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [StatusW-1:0] status,
    output logic               data_valid,
    output logic [7:0]         data_byte,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [SizeW-1:0]   cfg_data
);

    logic              in_q_valid_reg;
    logic [7:0]        in_q_byte_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    logic [SizeW-1:0]  max_payload_reg;
    logic              collect_reg;
    logic              advance;
    logic              in_take;
    byte_class_t       cls;
    result_t           res;

    // Move the held byte forward when the result register is free
    assign advance  = in_q_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_q_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= '1;
            collect_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                REG_COLLECT:     collect_reg     <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_q_valid_reg <= 1'b0;
        else if (in_take)
            in_q_valid_reg <= 1'b1;
        else if (advance)
            in_q_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_q_byte_reg <= in_byte;
    end

    hcbd_classify u_classify (
        .byte_in (in_q_byte_reg),
        .cls     (cls)
    );

    hcbd_step #(
        .MAX_SIZE_DIGITS (MAX_SIZE_DIGITS)
    ) u_step (
        .clk             (clk),
        .rst_n           (rst_n),
        .step_en         (advance),
        .byte_in         (in_q_byte_reg),
        .cls             (cls),
        .max_payload     (max_payload_reg),
        .collect_payload (collect_reg),
        .res             (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_reg.status;
    assign data_valid = out_reg.data_valid;
    assign data_byte  = out_reg.data_byte;

    // Payload beats only come while the body is still running
    `HCBD_NEVER(a_data_while_run, clk, rst_n,
                out_valid_reg && out_reg.data_valid && out_reg.status != ST_RUN)
    // Input backpressure only when a byte is held and cannot move
    `HCBD_ASSERT(a_stall_cause, clk, rst_n,
                 in_stall |-> in_q_valid_reg && out_valid_reg && out_stall)

endmodule

@@ bench/http_chunked_body_decoder_tb.sv @@
// Self-checking bench for http_chunked_body_decoder: streams framed chunk bodies,
// predicts each status beat in a scoreboard class and compares every output beat.
// Depends on hcbd_pkg and the decoder RTL; random idling on both channels.
import hcbd_pkg::*;

localparam int unsigned MAX_DIGITS     = 16;
localparam int unsigned ITEM_TARGET    = 1650;
localparam int unsigned DRAIN_CYCLES   = 4;
localparam int unsigned WATCHDOG_LIMIT = 2000;

localparam string HEX_LOWER  = "0123456789abcdef";
localparam string HEX_UPPER  = "0123456789ABCDEF";
localparam string SEPARATORS = "()<>@,;:\\\"/[]?={} ";
localparam string TOKEN_CHARS =
    "!#$%&'*+-.^_`|~0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";

typedef enum logic [3:0] {
    SIZE_HEAD  = 4'd0,
    SIZE_DIGIT = 4'd1,
    SIZE_EXT   = 4'd2,
    SIZE_LF    = 4'd3,
    DATA_BODY  = 4'd4,
    DATA_CR    = 4'd5,
    DATA_LF    = 4'd6,
    TAIL_CR    = 4'd10,
    TAIL_LF    = 4'd11
} parse_phase_e;

typedef enum int unsigned {
    END_CLEAN,
    END_BAD_FIRST,
    END_LONG_SIZE,
    END_WIDE_SIZE,
    END_BAD_EXT,
    END_BAD_SIZE_TAIL,
    END_SIZE_LF,
    END_BUDGET,
    END_DATA_CR,
    END_DATA_LF,
    END_LAST_CR,
    END_LAST_LF
} body_end_e;

// Tracks the chunk parser and holds the beats still owed by the decoder
class chunk_scoreboard;
    logic [31:0]  max_payload;
    logic         collect;
    parse_phase_e phase;
    int unsigned  digits;
    logic [31:0]  size_acc;
    logic         size_ovf;
    logic [31:0]  bytes_left;
    logic [31:0]  payload_total;
    logic [1:0]   body_status;
    result_t      expected_beats[$];
    int unsigned  mismatches;

    function new();
        max_payload   = 32'hFFFF_FFFF;
        collect       = 1'b1;
        phase         = SIZE_HEAD;
        digits        = 0;
        size_acc      = '0;
        size_ovf      = 1'b0;
        bytes_left    = '0;
        payload_total = '0;
        body_status   = ST_RUN;
        mismatches    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
        case (idx)
            REG_MAX_PAYLOAD: max_payload = value;
            REG_COLLECT:     collect = value[0];
            default:         ;
        endcase
    endfunction

    // Bit 4 flags a hex digit, bits 3:0 carry its value
    function logic [4:0] hex_digit(logic [7:0] b);
        if (b >= "0" && b <= "9")
            return {1'b1, 4'(b - "0")};
        if (b >= "a" && b <= "f")
            return {1'b1, 4'(b - "a" + 8'd10)};
        if (b >= "A" && b <= "F")
            return {1'b1, 4'(b - "A" + 8'd10)};
        return 5'd0;
    endfunction

    // Controls, high bytes, space and separators may not appear in an extension
    function logic ext_byte_illegal(logic [7:0] b);
        if (b <= 8'h1f || b >= 8'h7f)
            return 1'b1;
        for (int i = 0; i < SEPARATORS.len(); i++)
        begin
            if (b == SEPARATORS[i])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function int unsigned pending();
        return expected_beats.size();
    endfunction

    // Advance the parser by one accepted byte and queue the beat it yields
    function void note_byte(logic [7:0] b);
        logic [4:0]  hx;
        logic        fail;
        logic [31:0] room;
        result_t     beat;
        hx   = hex_digit(b);
        fail = 1'b0;
        beat = '0;
        if (body_status == ST_RUN)
        begin
            case (phase)
                SIZE_HEAD:
                begin
                    if (hx[4])
                    begin
                        size_acc = {28'd0, hx[3:0]};
                        size_ovf = 1'b0;
                        digits   = 1;
                        phase    = SIZE_DIGIT;
                    end
                    else
                        fail = 1'b1;
                end
                SIZE_DIGIT:
                begin
                    if (hx[4])
                    begin
                        if (digits < MAX_DIGITS)
                        begin
                            // flag bits shifted past 32
                            if (size_acc[31:28] != 4'd0)
                                size_ovf = 1'b1;
                            size_acc = {size_acc[27:0], hx[3:0]};
                            digits++;
                        end
                        else
                            fail = 1'b1;
                    end
                    else if (b == CHR_SEMI)
                        phase = SIZE_EXT;
                    else if (b == CHR_CR)
                        phase = SIZE_LF;
                    else
                        fail = 1'b1;
                end
                SIZE_EXT:
                begin
                    if (b == CHR_CR)
                        phase = SIZE_LF;
                    else if (ext_byte_illegal(b))
                        fail = 1'b1;
                end
                SIZE_LF:
                begin
                    if (b == CHR_LF && !size_ovf)
                    begin
                        // budget left, saturated at zero
                        room = (max_payload > payload_total) ? max_payload - payload_total : '0;
                        if (size_acc > room)
                            fail = 1'b1;
                        else if (size_acc != '0)
                        begin
                            bytes_left = size_acc;
                            phase      = DATA_BODY;
                        end
                        else
                            phase = TAIL_CR;
                    end
                    else
                        fail = 1'b1;
                end
                DATA_BODY:
                begin
                    if (collect)
                    begin
                        beat.data_valid = 1'b1;
                        beat.data_byte  = b;
                        payload_total++;
                    end
                    bytes_left--;
                    if (bytes_left == '0)
                        phase = DATA_CR;
                end
                DATA_CR:
                begin
                    if (b == CHR_CR)
                        phase = DATA_LF;
                    else
                        fail = 1'b1;
                end
                DATA_LF:
                begin
                    if (b == CHR_LF)
                        phase = SIZE_HEAD;
                    else
                        fail = 1'b1;
                end
                TAIL_CR:
                begin
                    if (b == CHR_CR)
                        phase = TAIL_LF;
                    else
                        fail = 1'b1;
                end
                TAIL_LF:
                begin
                    if (b == CHR_LF)
                        body_status = ST_DONE;
                    else
                        fail = 1'b1;
                end
                default: fail = 1'b1;
            endcase
            if (fail)
            begin
                body_status = ST_ERR;
                beat.data_valid = 1'b0;
                beat.data_byte  = 8'd0;
            end
        end
        beat.status = body_status;
        expected_beats.push_back(beat);
    endfunction

    task report(string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Compare one output beat with the oldest owed beat
    task check_beat(logic [1:0] st, logic dv, logic [7:0] db);
        result_t want;
        if (expected_beats.size() == 0)
        begin
            report($sformatf("unexpected beat status=%0d valid=%0d byte=%02h", st, dv, db));
            return;
        end
        want = expected_beats.pop_front();
        if (st !== want.status)
            report($sformatf("status %0d, want %0d", st, want.status));
        if (dv !== want.data_valid)
            report($sformatf("data_valid %0d, want %0d", dv, want.data_valid));
        if (db !== want.data_byte)
            report($sformatf("data_byte %02h, want %02h", db, want.data_byte));
    endtask
endclass

module http_chunked_body_decoder_tb;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [7:0]          in_byte = 8'd0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [StatusW-1:0]  status;
    logic                data_valid;
    logic [7:0]          data_byte;
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_index = 2'd0;
    logic [SizeW-1:0]    cfg_data = '0;

    chunk_scoreboard     sb;
    int unsigned         bytes_sent = 0;
    int unsigned         quiet_cycles = 0;
    logic                steady = 1'b0;

    http_chunked_body_decoder #(
        .MAX_SIZE_DIGITS(MAX_DIGITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .data_valid (data_valid),
        .data_byte  (data_byte),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sample both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_byte(in_byte);
            if (out_valid && !out_stall)
                sb.check_beat(status, data_valid, data_byte);
        end
    end

    // Abort when no beat moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stall the output in stretches: long free runs, short bursts, rare long holds
    initial
    begin
        int unsigned pick;
        int unsigned hold;
        @(posedge rst_n);
        forever
        begin
            pick = $urandom_range(0, 99);
            @(negedge clk);
            if (pick < 55)
            begin
                out_stall <= 1'b0;
                hold = $urandom_range(1, 40);
            end
            else if (pick < 92)
            begin
                out_stall <= 1'b1;
                hold = $urandom_range(1, 3);
            end
            else
            begin
                out_stall <= 1'b1;
                hold = $urandom_range(8, 40);
            end
            repeat (hold - 1) @(negedge clk);
        end
    end

    function automatic int unsigned idle_gap();
        int unsigned pick;
        if (steady)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if ($urandom_range(0, 1) == 1)
            return HEX_UPPER[v];
        return HEX_LOWER[v];
    endfunction

    // Offer one byte after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        bytes_sent++;
    endtask

    // Drop valid and wait until every owed beat has come out
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // Emit a size field of the given digit count, zero padded on the left
    task automatic send_size(input logic [31:0] value, input int unsigned width);
        logic [3:0] digit;
        for (int i = width; i > 0; i--)
        begin
            digit = (i > 8) ? 4'd0 : value[4*(i-1) +: 4];
            send_byte(hex_char(digit));
        end
    endtask

    task automatic send_ext();
        send_byte(CHR_SEMI);
        repeat ($urandom_range(0, 6))
            send_byte(TOKEN_CHARS[$urandom_range(0, TOKEN_CHARS.len() - 1)]);
    endtask

    task automatic send_crlf();
        send_byte(CHR_CR);
        send_byte(CHR_LF);
    endtask

    function automatic int unsigned min_digits(logic [31:0] value);
        int unsigned n;
        n = 1;
        while (n < 8 && (value >> (4 * n)) != 0)
            n++;
        return n;
    endfunction

    // Data bytes lean toward CR and LF now and then to test framing inside data
    function automatic logic [7:0] data_pick();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            return CHR_CR;
        if (pick < 6)
            return CHR_LF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_header(input logic [31:0] size);
        int unsigned ndig;
        ndig = min_digits(size);
        if ($urandom_range(0, 9) == 0)
            ndig = $urandom_range(ndig, MAX_DIGITS);
        send_size(size, ndig);
        if ($urandom_range(0, 3) == 0)
            send_ext();
    endtask

    task automatic send_chunk(input logic [31:0] size);
        steady = ($urandom_range(0, 4) == 0);
        send_header(size);
        send_crlf();
        repeat (size)
            send_byte(data_pick());
        send_crlf();
    endtask

    // One group of well-formed chunks under a fresh register setting
    task automatic run_phase();
        int unsigned nchunks;
        int unsigned sizes[$];
        int unsigned pick;
        logic [31:0] need;
        nchunks = $urandom_range(1, 6);
        need = '0;
        repeat (nchunks)
        begin
            pick = $urandom_range(0, 19);
            sizes.push_back((pick == 0) ? $urandom_range(25, 160) : $urandom_range(1, 24));
            need += sizes[$];
        end
        wait_idle();
        write_reg(REG_COLLECT, ($urandom_range(0, 9) < 7) ? 32'd1 : 32'd0);
        pick = $urandom_range(0, 99);
        if (pick < 35)
            write_reg(REG_MAX_PAYLOAD, 32'hFFFF_FFFF);
        else if (pick < 65)
            write_reg(REG_MAX_PAYLOAD, sb.payload_total + need);
        else
            write_reg(REG_MAX_PAYLOAD, sb.payload_total + need + $urandom_range(1, 300));
        foreach (sizes[i])
            send_chunk(sizes[i]);
    endtask

    // Finish the body cleanly or with one framing, size or budget fault, then trail noise
    task automatic end_body();
        body_end_e   kind;
        int unsigned pick;
        logic [7:0]  b;
        logic [4:0]  hx;
        logic [31:0] limit_val;
        logic [31:0] room;
        logic [31:0] size;
        pick = $urandom_range(0, 21);
        kind = (pick < 11) ? END_CLEAN : body_end_e'(pick - 10);
        wait_idle();
        write_reg(REG_MAX_PAYLOAD, 32'hFFFF_FFFF);
        steady = 1'b0;
        size = $urandom_range(1, 8);
        case (kind)
            END_CLEAN:
            begin
                // last chunk passes even with no budget left
                pick = $urandom_range(0, 2);
                if (pick == 0)
                    write_reg(REG_MAX_PAYLOAD, 32'd0);
                else if (pick == 1)
                    write_reg(REG_MAX_PAYLOAD,
                              (sb.payload_total == 0) ? 32'd0 : sb.payload_total - 1);
                send_size(32'd0, $urandom_range(1, MAX_DIGITS));
                if ($urandom_range(0, 1) == 1)
                    send_ext();
                send_crlf();
                send_crlf();
            end
            END_BAD_FIRST:
            begin
                do
                begin
                    b  = 8'($urandom_range(0, 255));
                    hx = sb.hex_digit(b);
                end
                while (hx[4]);
                send_byte(b);
            end
            END_LONG_SIZE:
            begin
                repeat (MAX_DIGITS + 1)
                    send_byte(hex_char(4'($urandom_range(0, 15))));
            end
            END_WIDE_SIZE:
            begin
                // leading nonzero digit pushed past bit 31
                pick = $urandom_range(9, MAX_DIGITS);
                send_byte(hex_char(4'($urandom_range(1, 15))));
                repeat (pick - 1)
                    send_byte(hex_char(4'($urandom_range(0, 15))));
                if ($urandom_range(0, 1) == 1)
                    send_ext();
                send_crlf();
            end
            END_BAD_EXT:
            begin
                send_size(size, 1);
                send_ext();
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CHR_CR || !sb.ext_byte_illegal(b));
                send_byte(b);
            end
            END_BAD_SIZE_TAIL:
            begin
                send_size(size, $urandom_range(1, 4));
                do
                begin
                    b  = 8'($urandom_range(0, 255));
                    hx = sb.hex_digit(b);
                end
                while (hx[4] || b == CHR_SEMI || b == CHR_CR);
                send_byte(b);
            end
            END_SIZE_LF:
            begin
                send_header(size);
                send_byte(CHR_CR);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CHR_LF);
                send_byte(b);
            end
            END_BUDGET:
            begin
                pick = $urandom_range(0, 2);
                if (pick == 0)
                    limit_val = 32'd0;
                else if (pick == 1)
                    limit_val = sb.payload_total + $urandom_range(0, 40);
                else
                    limit_val = (sb.payload_total == 0) ? 32'd0
                                : $urandom_range(0, sb.payload_total - 1);
                write_reg(REG_MAX_PAYLOAD, limit_val);
                room = (limit_val > sb.payload_total) ? limit_val - sb.payload_total : '0;
                size = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                       : room + $urandom_range(1, 64);
                send_header(size);
                send_crlf();
            end
            END_DATA_CR, END_DATA_LF:
            begin
                send_header(size);
                send_crlf();
                repeat (size)
                    send_byte(data_pick());
                if (kind == END_DATA_LF)
                    send_byte(CHR_CR);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == ((kind == END_DATA_LF) ? CHR_LF : CHR_CR));
                send_byte(b);
            end
            END_LAST_CR, END_LAST_LF:
            begin
                send_size(32'd0, 1);
                send_crlf();
                if (kind == END_LAST_LF)
                    send_byte(CHR_CR);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == ((kind == END_LAST_LF) ? CHR_LF : CHR_CR));
                send_byte(b);
            end
            default: ;
        endcase
        // everything past the end is ignored and answers the held status
        repeat ($urandom_range(16, 40))
            send_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Full-width padded size, an extension, and the byte extremes as data
        send_size(32'd2, MAX_DIGITS);
        send_byte(CHR_SEMI);
        send_byte("x");
        send_crlf();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_crlf();

        while (bytes_sent < ITEM_TARGET)
            run_phase();
        end_body();

        wait_idle();
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/hcbd_pkg.sv
hw/rtl/hcbd_classify.sv
hw/rtl/hcbd_step.sv
hw/rtl/http_chunked_body_decoder.sv
bench/http_chunked_body_decoder_tb.sv
